[sv/tlpc_pkg.sv]
// Shared types and constants for the traffic light preemption controller.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tlpc_pkg;

  // Timing registers are 16 bits wide, whatever the internal counter width.
  localparam int CFG_W = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GREEN  = 2'd0;
  localparam logic [1:0] CFG_YELLOW = 2'd1;
  localparam logic [1:0] CFG_HOLD   = 2'd2;

  // Reset values of the timing registers.
  localparam logic [CFG_W-1:0] GREEN_RESET  = 16'd10;
  localparam logic [CFG_W-1:0] YELLOW_RESET = 16'd5;
  localparam logic [CFG_W-1:0] HOLD_RESET   = 16'd5;

  // Request kinds.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_EMERG = 1'b1;

  // Lamp codes.
  localparam logic [1:0] LAMP_GREEN  = 2'd0;
  localparam logic [1:0] LAMP_YELLOW = 2'd1;
  localparam logic [1:0] LAMP_RED    = 2'd2;

  // Signal groups.
  localparam logic GRP_NS = 1'b0;
  localparam logic GRP_EW = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [1:0] emergency_dir;
  } in_t;

  typedef struct packed {
    logic [1:0] ns_light;
    logic [1:0] ew_light;
    logic       in_emergency;
  } out_t;

endpackage

`default_nettype wire

[sv/traffic_light_preempt_controller_core.sv]
// Top level of the two-group traffic light controller with emergency preemption.
// Depends on tlpc_pkg for the beat types, lamp codes and register indexes.
`default_nettype none

// Each accepted beat is a time tick or an emergency request and yields exactly
// one result beat with both lamp states and the emergency flag. The block takes
// one beat per clock cycle unless held back by a stalled result. A beat waits in
// the input register, and its result is offered on out_ once the beat moves on
// into the result register. The phase counter and lamp state are updated as the
// beat leaves the input register. The timing registers are written through the
// cfg_ channel, which is always ready, and should only be written while no beat
// is in flight.
module traffic_light_preempt_controller_core #(
  parameter int TICK_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  tlpc_pkg::in_t          in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output tlpc_pkg::out_t               out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [1:0]                   cfg_addr,
  input  wire  [tlpc_pkg::CFG_W-1:0]   cfg_data
);

  // Working width for the length-to-count conversion.
  localparam int CW = (TICK_WIDTH > tlpc_pkg::CFG_W) ? TICK_WIDTH : tlpc_pkg::CFG_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GREEN,
    PH_YELLOW,
    PH_HOLD
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic                      grp_r, grp_nxt;
  logic [TICK_WIDTH-1:0]     rem_r, rem_nxt;

  logic [tlpc_pkg::CFG_W-1:0] green_r, yellow_r, hold_r;

  logic                      s1_valid_r;
  tlpc_pkg::in_t             s1_data_r;
  logic                      out_valid_r;
  tlpc_pkg::out_t            out_data_r, out_data_nxt;

  logic                      s1_adv;
  logic                      rem_zero;
  logic [1:0]                act_lamp;

  // Phase length to down-counter load value: zero counts as one, and lengths
  // beyond the counter range saturate at its largest value.
  function automatic logic [TICK_WIDTH-1:0] load_count(
    input logic [tlpc_pkg::CFG_W-1:0] len
  );
    logic [CW-1:0] c;
    logic [CW-1:0] cmax;
    c = '0;
    if (len != '0) begin
      c = CW'(len - tlpc_pkg::CFG_W'(1));
    end
    cmax = CW'({TICK_WIDTH{1'b1}});
    if (c > cmax) begin
      c = cmax;
    end
    return c[TICK_WIDTH-1:0];
  endfunction

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rem_zero  = (rem_r == '0);

  always_comb begin
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    rem_nxt   = rem_r;
    if (s1_data_r.req_type == tlpc_pkg::REQ_EMERG) begin
      // A request during a running hold changes nothing.
      if (phase_r != PH_HOLD) begin
        phase_nxt = PH_HOLD;
        grp_nxt   = s1_data_r.emergency_dir[1] ? tlpc_pkg::GRP_NS : tlpc_pkg::GRP_EW;
        rem_nxt   = load_count(hold_r);
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_GREEN;
          rem_nxt   = load_count(green_r);
        end
        PH_GREEN: begin
          if (!rem_zero) begin
            rem_nxt = rem_r - TICK_WIDTH'(1);
          end else begin
            phase_nxt = PH_YELLOW;
            rem_nxt   = load_count(yellow_r);
          end
        end
        PH_YELLOW: begin
          if (!rem_zero) begin
            rem_nxt = rem_r - TICK_WIDTH'(1);
          end else begin
            grp_nxt   = !grp_r;
            phase_nxt = PH_GREEN;
            rem_nxt   = load_count(green_r);
          end
        end
        default: begin
          if (!rem_zero) begin
            rem_nxt = rem_r - TICK_WIDTH'(1);
          end else begin
            phase_nxt = PH_GREEN;
            rem_nxt   = load_count(green_r);
          end
        end
      endcase
    end

    case (phase_nxt)
      PH_GREEN:  act_lamp = tlpc_pkg::LAMP_GREEN;
      PH_HOLD:   act_lamp = tlpc_pkg::LAMP_GREEN;
      PH_YELLOW: act_lamp = tlpc_pkg::LAMP_YELLOW;
      default:   act_lamp = tlpc_pkg::LAMP_RED;
    endcase

    if (grp_nxt == tlpc_pkg::GRP_NS) begin
      out_data_nxt.ns_light = act_lamp;
      out_data_nxt.ew_light = tlpc_pkg::LAMP_RED;
    end else begin
      out_data_nxt.ns_light = tlpc_pkg::LAMP_RED;
      out_data_nxt.ew_light = act_lamp;
    end
    out_data_nxt.in_emergency = (phase_nxt == PH_HOLD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      grp_r       <= tlpc_pkg::GRP_NS;
      rem_r       <= '0;
      green_r     <= tlpc_pkg::GREEN_RESET;
      yellow_r    <= tlpc_pkg::YELLOW_RESET;
      hold_r      <= tlpc_pkg::HOLD_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          tlpc_pkg::CFG_GREEN:  green_r  <= cfg_data;
          tlpc_pkg::CFG_YELLOW: yellow_r <= cfg_data;
          tlpc_pkg::CFG_HOLD:   hold_r   <= cfg_data;
          default: ;
        endcase
      end

      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      if (s1_adv) begin
        phase_r     <= phase_nxt;
        grp_r       <= grp_nxt;
        rem_r       <= rem_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/tlpc_checker.sv]
// Port-level checks for the traffic light preemption controller, with the bind
// that attaches them to the top level. Depends on tlpc_pkg for lamp codes.
`default_nettype none

module tlpc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire tlpc_pkg::out_t out_data
);

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result beat is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The two groups never show a non-red lamp at the same time.
  a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ns_light == tlpc_pkg::LAMP_RED) ||
                  (out_data.ew_light == tlpc_pkg::LAMP_RED))
    else $error("both groups released at once");

  // During an emergency hold one group is green.
  a_hold_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_emergency |->
      (out_data.ns_light == tlpc_pkg::LAMP_GREEN) ||
      (out_data.ew_light == tlpc_pkg::LAMP_GREEN))
    else $error("emergency flagged without a green group");

endmodule

bind traffic_light_preempt_controller_core tlpc_checker u_tlpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
